>>> sv/tsi_pkg.sv
// ----------------------------------------------------------------------------
// tsi_pkg
// shared types and constants of the track spline interpolator
// ----------------------------------------------------------------------------
`default_nettype none

package tsi_pkg;

    localparam int unsigned U_FRAC_BITS    = 16;
    localparam int unsigned TIME_FRAC_BITS = 8;
    localparam int unsigned TENSION_FRAC   = 16;
    localparam int unsigned NEED_MARGIN    = ((1 << TIME_FRAC_BITS) + 5) / 10;
    localparam logic [16:0] TENSION_RESET  = 17'd64225;

    localparam logic [1:0] OP_PUSH  = 2'd0;
    localparam logic [1:0] OP_QUERY = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;
    localparam logic [1:0] OP_SPARE = 2'd3;

    localparam int signed LAT_MAX = 5400000;
    localparam int signed LON_MAX = 10800000;
    localparam int signed ALT_MIN = -1000;
    localparam int signed ALT_MAX = 20000;

    // datapath operations
    typedef enum logic [3:0] {
        DP_NOP,
        DP_LOAD,      // latch item, compute d and n
        DP_UPDATE,    // push or clear on the window
        DP_DIV_START,
        DP_DIV_STEP,
        DP_U2,        // latch u
        DP_U3,        // u*u
        DP_AB,        // u2*u
        DP_TA,        // a and b
        DP_TB,        // tension*a
        DP_COEF,      // tension*b
        DP_MAC,       // weights, then one weighted point per cycle
        DP_ROUND,     // add point 0
        DP_FINISH     // round, pick and build result item
    } t_dp_cmd;

    typedef struct packed {
        t_dp_cmd    cmd;
        logic [1:0] slot;
    } t_ctrl;

    typedef struct packed {
        logic       is_query;
        logic       interp;    // query needs the full spline
        logic       div_done;
    } t_status;

endpackage

`default_nettype wire

>>> sv/tsi_datapath.sv
// ----------------------------------------------------------------------------
// tsi_datapath
// window storage, shared divider and multiplier, result register
// ----------------------------------------------------------------------------
`default_nettype none

module tsi_datapath (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire tsi_pkg::t_ctrl   i_ctrl,
    output tsi_pkg::t_status      o_status,
    input  wire logic [16:0]      i_tension,
    input  wire logic [1:0]       i_op,
    input  wire logic [24:0]      i_time,
    input  wire logic signed [23:0] i_lat,
    input  wire logic signed [24:0] i_lon,
    input  wire logic signed [15:0] i_alt,
    output logic [119:0]          o_result
);

    localparam int unsigned UF = tsi_pkg::U_FRAC_BITS;
    localparam int unsigned DW = 26 + UF;

    logic [24:0]        r_tm [4];
    logic signed [23:0] r_la [4];
    logic signed [24:0] r_lo [4];
    logic signed [15:0] r_al [4];
    logic [2:0]         r_fill;

    logic [1:0]         r_op;
    logic [24:0]        r_t;
    logic signed [23:0] r_nla;
    logic signed [24:0] r_nlo;
    logic signed [15:0] r_nal;
    logic               r_acc;

    logic signed [26:0] r_d, r_n;
    logic [DW-1:0]      r_rem, r_quo;
    logic [5:0]         r_cnt;
    logic signed [UF+2:0] r_u, r_u2, r_u3;
    logic signed [UF+4:0] r_a, r_b;
    logic signed [UF+5:0] r_ta, r_tb;
    logic signed [UF+7:0] r_c [4];
    logic signed [UF+30:0] r_sla, r_slo, r_sal;
    logic signed [23:0] r_ola;
    logic signed [24:0] r_olo;
    logic signed [15:0] r_oal;

    // multiplier operands and divider shift and subtract
    logic signed [UF+2:0] w_mb;
    logic signed [2*UF+5:0] w_uu;
    logic signed [UF+24:0] w_tp;
    logic signed [UF+4:0] w_tsel;
    logic signed [DW:0]   w_sub;
    logic [DW-1:0]        w_rsh;

    function automatic logic signed [UF+5:0] rshift_t(input logic signed [UF+24:0] v);
        logic signed [UF+24:0] x;
        begin
            x = v + (UF+25)'(1 << (tsi_pkg::TENSION_FRAC - 1));
            rshift_t = (UF+6)'(x >>> tsi_pkg::TENSION_FRAC);
        end
    endfunction

    function automatic logic signed [UF+30:0] rnd(input logic signed [UF+30:0] v);
        rnd = (v + (UF+31)'(1 << (UF - 1))) >>> UF;
    endfunction

    always_comb begin
        w_mb = (i_ctrl.cmd == tsi_pkg::DP_U3) ? r_u : r_u2;
        w_uu = w_mb * r_u;
        w_tsel = (i_ctrl.cmd == tsi_pkg::DP_TB) ? r_a : r_b;
        w_tp = $signed({1'b0, i_tension}) * w_tsel;
        w_rsh = {r_rem[DW-2:0], r_quo[DW-1]};
        w_sub = $signed({1'b0, w_rsh}) - $signed({{(DW-25){1'b0}}, r_d[25:0]});
    end

    logic signed [UF+30:0] w_ml, w_mo, w_mal;
    always_comb begin
        w_ml  = (UF+31)'(r_la[i_ctrl.slot]) * (UF+31)'(r_c[i_ctrl.slot]);
        w_mo  = (UF+31)'(r_lo[i_ctrl.slot]) * (UF+31)'(r_c[i_ctrl.slot]);
        w_mal = (UF+31)'(r_al[i_ctrl.slot]) * (UF+31)'(r_c[i_ctrl.slot]);
    end

    logic [24:0] w_tmax;
    logic        w_need;
    always_comb begin
        w_tmax = r_tm[0];
        for (int k = 1; k < 4; k++) if (r_tm[k] > w_tmax) w_tmax = r_tm[k];
        w_need = (r_fill < 3'd4) ||
                 ({1'b0, r_tm[2]} <= {1'b0, r_t} + 26'(tsi_pkg::NEED_MARGIN));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 4; k++) begin
                r_tm[k] <= '0; r_la[k] <= '0; r_lo[k] <= '0; r_al[k] <= '0;
            end
            r_fill <= '0;
        end else if (i_ctrl.cmd == tsi_pkg::DP_UPDATE) begin
            if (r_op == tsi_pkg::OP_PUSH) begin
                if (r_fill < 3'd4) r_fill <= r_fill + 3'd1;
                if (r_tm[3] > r_t) begin
                    for (int k = 0; k < 4; k++) begin
                        r_tm[k] <= r_t; r_la[k] <= r_nla;
                        r_lo[k] <= r_nlo; r_al[k] <= r_nal;
                    end
                end else begin
                    for (int k = 0; k < 3; k++) begin
                        r_tm[k] <= r_tm[k+1]; r_la[k] <= r_la[k+1];
                        r_lo[k] <= r_lo[k+1]; r_al[k] <= r_al[k+1];
                    end
                    r_tm[3] <= r_t; r_la[3] <= r_nla;
                    r_lo[3] <= r_nlo; r_al[3] <= r_nal;
                end
            end else if (r_op == tsi_pkg::OP_CLEAR) begin
                for (int k = 0; k < 4; k++) begin
                    r_tm[k] <= '0; r_la[k] <= '0; r_lo[k] <= '0; r_al[k] <= '0;
                end
                r_fill <= '0;
            end
        end
    end

    // payload, divider and spline arithmetic registers
    always_ff @(posedge i_clk) begin
        unique case (i_ctrl.cmd)
            tsi_pkg::DP_LOAD: begin
                r_op <= i_op; r_t <= i_time;
                r_nla <= i_lat; r_nlo <= i_lon; r_nal <= i_alt;
                r_acc <= 1'b0;
                if (r_tm[2] >= r_tm[1]) begin
                    r_d <= $signed({2'b0, r_tm[2]}) - $signed({2'b0, r_tm[1]});
                    r_n <= $signed({2'b0, i_time}) - $signed({2'b0, r_tm[1]});
                end else begin
                    r_d <= $signed({2'b0, r_tm[1]}) - $signed({2'b0, r_tm[2]});
                    r_n <= $signed({2'b0, r_tm[1]}) - $signed({2'b0, i_time});
                end
            end
            tsi_pkg::DP_UPDATE: begin
                r_acc <= (r_op == tsi_pkg::OP_PUSH) && !(r_tm[3] > r_t);
            end
            tsi_pkg::DP_DIV_START: begin
                // dividend is n*2^UF + d/2, n <= d here
                r_quo <= DW'({r_n[25:0], {UF{1'b0}}}) + DW'(r_d[25:1]);
                r_rem <= '0;
                r_cnt <= 6'(DW);
            end
            tsi_pkg::DP_DIV_STEP: begin
                if (!w_sub[DW]) begin
                    r_rem <= w_sub[DW-1:0];
                    r_quo <= {r_quo[DW-2:0], 1'b1};
                end else begin
                    r_rem <= w_rsh;
                    r_quo <= {r_quo[DW-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 6'd1;
            end
            tsi_pkg::DP_U2: begin
                r_u  <= (UF+3)'($signed({1'b0, r_quo}));
                r_u2 <= '0;
            end
            tsi_pkg::DP_U3: r_u2 <= (UF+3)'((w_uu + (2*UF+6)'(1 << (UF-1))) >>> UF);
            tsi_pkg::DP_AB: begin
                r_u3 <= (UF+3)'((w_uu + (2*UF+6)'(1 << (UF-1))) >>> UF);
            end
            tsi_pkg::DP_TA: begin
                r_a <= (UF+5)'(r_u3) - (UF+5)'(r_u2);
                r_b <= -(UF+5)'(r_u3) + ((UF+5)'(r_u2) <<< 1) - (UF+5)'(r_u);
            end
            tsi_pkg::DP_TB: r_ta <= rshift_t(w_tp);
            tsi_pkg::DP_COEF: begin
                r_tb <= rshift_t(w_tp);
            end
            tsi_pkg::DP_MAC: begin
                if (i_ctrl.slot == 2'd0) begin
                    r_c[0] <= (UF+8)'(r_tb);
                    r_c[1] <= (UF+8)'(1 << UF) + ((UF+8)'(r_u3) <<< 1)
                              - (UF+8)'(3) * (UF+8)'(r_u2) - (UF+8)'(r_ta);
                    r_c[2] <= -((UF+8)'(r_u3) <<< 1) + (UF+8)'(3) * (UF+8)'(r_u2)
                              - (UF+8)'(r_tb);
                    r_c[3] <= (UF+8)'(r_ta);
                    r_sla <= '0; r_slo <= '0; r_sal <= '0;
                end else begin
                    r_sla <= r_sla + w_ml; r_slo <= r_slo + w_mo; r_sal <= r_sal + w_mal;
                end
            end
            tsi_pkg::DP_ROUND: begin
                r_sla <= r_sla + w_ml; r_slo <= r_slo + w_mo; r_sal <= r_sal + w_mal;
            end
            default: ;
        endcase
    end

    // coordinate selection: rounded spline or window edge point
    logic signed [UF+30:0] w_fla, w_flo, w_fal;
    always_comb begin
        w_fla = rnd(r_sla); w_flo = rnd(r_slo); w_fal = rnd(r_sal);
        if (r_fill < 3'd4) begin
            w_fla = (UF+31)'(r_la[3]); w_flo = (UF+31)'(r_lo[3]);
            w_fal = (UF+31)'(r_al[3]);
        end else if (r_d == 0 || r_n < 0) begin
            w_fla = (UF+31)'(r_la[1]); w_flo = (UF+31)'(r_lo[1]);
            w_fal = (UF+31)'(r_al[1]);
        end else if (r_n > r_d) begin
            w_fla = (UF+31)'(r_la[2]); w_flo = (UF+31)'(r_lo[2]);
            w_fal = (UF+31)'(r_al[2]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.cmd == tsi_pkg::DP_FINISH) begin
            if (r_op == tsi_pkg::OP_QUERY) begin
                r_ola <= w_fla > tsi_pkg::LAT_MAX ? 24'(tsi_pkg::LAT_MAX) :
                         w_fla < -tsi_pkg::LAT_MAX ? 24'(-tsi_pkg::LAT_MAX) : 24'(w_fla);
                r_olo <= w_flo > tsi_pkg::LON_MAX ? 25'(tsi_pkg::LON_MAX) :
                         w_flo < -tsi_pkg::LON_MAX ? 25'(-tsi_pkg::LON_MAX) : 25'(w_flo);
                r_oal <= w_fal > tsi_pkg::ALT_MAX ? 16'(tsi_pkg::ALT_MAX) :
                         w_fal < tsi_pkg::ALT_MIN ? 16'(tsi_pkg::ALT_MIN) : 16'(w_fal);
            end else begin
                r_ola <= '0; r_olo <= '0; r_oal <= '0;
            end
        end
    end

    assign o_result = {3'd0, w_tmax, r_tm[0], w_need, r_acc, r_oal, r_olo, r_ola};

    always_comb begin
        o_status.is_query = (r_op == tsi_pkg::OP_QUERY);
        o_status.interp   = (r_fill >= 3'd4) && (r_d != 0) && (r_n >= 0) && (r_n <= r_d);
        o_status.div_done = (r_cnt == 6'd1);
    end

endmodule

`default_nettype wire

>>> sv/tsi_ctrl.sv
// ----------------------------------------------------------------------------
// tsi_ctrl
// sequencer for push, clear and query
// ----------------------------------------------------------------------------
`default_nettype none

module tsi_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    input  wire tsi_pkg::t_status i_status,
    output tsi_pkg::t_ctrl        o_ctrl
);

    typedef enum logic [3:0] {
        S_IDLE, S_DECIDE, S_DIVS, S_DIV, S_U2, S_U3, S_AB, S_TA, S_TB, S_COEF,
        S_MAC, S_ROUND, S_FIN, S_OUT
    } t_state;

    t_state     r_state;
    logic [1:0] r_slot;

    assign o_in_ready  = (r_state == S_IDLE) || (r_state == S_OUT && i_out_ready);
    assign o_out_valid = (r_state == S_OUT);

    always_comb begin
        o_ctrl.slot = r_slot;
        unique case (r_state)
            S_IDLE:   o_ctrl.cmd = (o_in_ready && i_in_valid) ? tsi_pkg::DP_LOAD : tsi_pkg::DP_NOP;
            S_OUT:    o_ctrl.cmd = (o_in_ready && i_in_valid) ? tsi_pkg::DP_LOAD : tsi_pkg::DP_NOP;
            S_DECIDE: o_ctrl.cmd = tsi_pkg::DP_UPDATE;
            S_DIVS:   o_ctrl.cmd = tsi_pkg::DP_DIV_START;
            S_DIV:    o_ctrl.cmd = tsi_pkg::DP_DIV_STEP;
            S_U2:     o_ctrl.cmd = tsi_pkg::DP_U2;
            S_U3:     o_ctrl.cmd = tsi_pkg::DP_U3;
            S_AB:     o_ctrl.cmd = tsi_pkg::DP_AB;
            S_TA:     o_ctrl.cmd = tsi_pkg::DP_TA;
            S_TB:     o_ctrl.cmd = tsi_pkg::DP_TB;
            S_COEF:   o_ctrl.cmd = tsi_pkg::DP_COEF;
            S_MAC:    o_ctrl.cmd = tsi_pkg::DP_MAC;
            S_ROUND:  o_ctrl.cmd = tsi_pkg::DP_ROUND;
            S_FIN:    o_ctrl.cmd = tsi_pkg::DP_FINISH;
            default:  o_ctrl.cmd = tsi_pkg::DP_NOP;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_slot  <= '0;
        end else begin
            unique case (r_state)
                S_IDLE, S_OUT: begin
                    if (o_in_ready && i_in_valid) r_state <= S_DECIDE;
                    else if (r_state == S_OUT && i_out_ready) r_state <= S_IDLE;
                end
                S_DECIDE: r_state <= (i_status.is_query && i_status.interp) ? S_DIVS : S_FIN;
                S_DIVS:   r_state <= S_DIV;
                S_DIV:    if (i_status.div_done) r_state <= S_U2;
                S_U2:     r_state <= S_U3;
                S_U3:     r_state <= S_AB;
                S_AB:     r_state <= S_TA;
                S_TA:     r_state <= S_TB;
                S_TB:     r_state <= S_COEF;
                S_COEF: begin
                    r_state <= S_MAC;
                    r_slot  <= 2'd0;
                end
                S_MAC: begin
                    // slot 0 loads weights, slots 1..3 add points 1..3,
                    // point 0 follows in the round step
                    r_slot <= r_slot + 2'd1;
                    if (r_slot == 2'd3) r_state <= S_ROUND;
                end
                S_ROUND:  r_state <= S_FIN;
                S_FIN:    r_state <= S_OUT;
                default:  r_state <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

>>> sv/track_spline_interpolator.sv
// ----------------------------------------------------------------------------
// track_spline_interpolator
// four point cardinal spline interpolator over a window of track points
// ----------------------------------------------------------------------------
// sequence: push, clear and window-edge queries go from decide straight to finish;
//   interpolated queries also run the 42-step radix-2 divider for u and the
//   shared multiplier for the powers and weights
// throughput: one request at a time; the next is taken as the result leaves
// reset: synchronous active low, window and fill count zero, tension 0.98
`default_nettype none

module track_spline_interpolator (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // op, sample_time, latitude, longitude, altitude
    input  wire logic [95:0] s_axis_tdata,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // lat_out, lon_out, alt_out, point_accepted, need_more,
    // window_min_time, window_max_time
    output logic [119:0]     m_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [1:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic [16:0]      r_tension;
    tsi_pkg::t_ctrl   w_ctrl;
    tsi_pkg::t_status w_status;

    // tension register at address 0
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_tension <= tsi_pkg::TENSION_RESET;
        else if (psel && penable && pwrite && paddr == 2'd0) r_tension <= pwdata[16:0];
    end
    assign pready = 1'b1;
    assign prdata = (paddr == 2'd0) ? {15'd0, r_tension} : 32'd0;

    tsi_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_status    (w_status),
        .o_ctrl      (w_ctrl)
    );

    tsi_datapath u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (w_ctrl),
        .o_status  (w_status),
        .i_tension (r_tension),
        .i_op      (s_axis_tdata[1:0]),
        .i_time    (s_axis_tdata[26:2]),
        .i_lat     (s_axis_tdata[50:27]),
        .i_lon     (s_axis_tdata[75:51]),
        .i_alt     (s_axis_tdata[91:76]),
        .o_result  (m_axis_tdata)
    );

endmodule

`default_nettype wire

>>> bench/track_spline_interpolator_tb.sv
// ----------------------------------------------------------------------------
// track_spline_interpolator_tb
// self-checking bench for the four point track spline interpolator
// ----------------------------------------------------------------------------
// a queue of requests, filled by an initial block, feeds a clocked driver;
// a clocked monitor compares every result with the oldest prediction from a
// behavioural copy of the window, spline weights and saturation. the tension
// register is rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module track_spline_interpolator_tb;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 120;

    typedef struct packed {
        logic [1:0]         op;
        logic [24:0]        stime;
        logic signed [23:0] lat;
        logic signed [24:0] lon;
        logic signed [15:0] alt;
    } t_request;

    typedef struct packed {
        logic signed [23:0] lat;
        logic signed [24:0] lon;
        logic signed [15:0] alt;
        logic               accepted;
        logic               need_more;
        logic [24:0]        tmin;
        logic [24:0]        tmax;
    } t_fix;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic [95:0]  s_axis_tdata = '0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [119:0] m_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic         psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [1:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;

    // stimulus queue and the predicted fixes awaiting their result
    t_request pending_reqs[$];
    t_fix     expected_fixes[$];

    // predictor copy of the block state
    logic [16:0]        mdl_tension;
    logic [24:0]        win_time[4];
    logic signed [23:0] win_lat[4];
    logic signed [24:0] win_lon[4];
    logic signed [15:0] win_alt[4];
    int                 win_fill;

    int  send_idle_pct = 0, recv_idle_pct = 0;
    bit  recv_hold = 1'b0;
    bit  in_taken = 1'b0;
    int  errors = 0, n_sent = 0, n_checked = 0, n_interp = 0, idle_cycles = 0;
    bit  timed_out = 1'b0;

    always #6 i_clk = ~i_clk;

    track_spline_interpolator u_dut (
        .i_clk, .i_rst_n,
        .s_axis_tdata, .s_axis_tvalid, .s_axis_tready,
        .m_axis_tdata, .m_axis_tvalid, .m_axis_tready,
        .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
    );

    // round to nearest, halves toward plus infinity (floor of v + half)
    function automatic longint rnd_shift(longint v, int s);
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic longint clamp(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // spline over the window; slot picks for the edge cases
    function automatic void spline_at(input logic [24:0] tq,
                                      output longint la, lo, al);
        longint d, n, u, u2, u3, a, b, ta, tb, one;
        longint c[4];
        int     pick;
        pick = -1;
        d = longint'(win_time[2]) - longint'(win_time[1]);
        n = longint'(tq) - longint'(win_time[1]);
        if (win_fill < 4) pick = 3;
        else if (d == 0) pick = 1;
        else begin
            if (d < 0) begin
                d = -d;
                n = -n;
            end
            if (n < 0) pick = 1;
            else if (n > d) pick = 2;
        end
        if (pick >= 0) begin
            la = win_lat[pick];
            lo = win_lon[pick];
            al = win_alt[pick];
            return;
        end
        n_interp++;
        one = longint'(1) << tsi_pkg::U_FRAC_BITS;
        u  = ((n << tsi_pkg::U_FRAC_BITS) + d / 2) / d;
        u2 = rnd_shift(u * u, tsi_pkg::U_FRAC_BITS);
        u3 = rnd_shift(u2 * u, tsi_pkg::U_FRAC_BITS);
        a  = u3 - u2;
        b  = -u3 + 2 * u2 - u;
        ta = rnd_shift(longint'(mdl_tension) * a, tsi_pkg::TENSION_FRAC);
        tb = rnd_shift(longint'(mdl_tension) * b, tsi_pkg::TENSION_FRAC);
        c[0] = tb;
        c[1] = one + 2 * u3 - 3 * u2 - ta;
        c[2] = -2 * u3 + 3 * u2 - tb;
        c[3] = ta;
        la = 0; lo = 0; al = 0;
        for (int k = 0; k < 4; k++) begin
            la += longint'(win_lat[k]) * c[k];
            lo += longint'(win_lon[k]) * c[k];
            al += longint'(win_alt[k]) * c[k];
        end
        la = rnd_shift(la, tsi_pkg::U_FRAC_BITS);
        lo = rnd_shift(lo, tsi_pkg::U_FRAC_BITS);
        al = rnd_shift(al, tsi_pkg::U_FRAC_BITS);
    endfunction

    // advance the predictor by one request and return the expected fix
    function automatic t_fix predict_fix(t_request r);
        t_fix   f;
        longint la, lo, al;
        f = '0;
        case (r.op)
            tsi_pkg::OP_PUSH: begin
                if (win_fill < 4) win_fill++;
                if (win_time[3] > r.stime) begin
                    // time ran backward: refill whole window
                    for (int k = 0; k < 4; k++) begin
                        win_time[k] = r.stime; win_lat[k] = r.lat;
                        win_lon[k] = r.lon;    win_alt[k] = r.alt;
                    end
                end else begin
                    for (int k = 0; k < 3; k++) begin
                        win_time[k] = win_time[k+1]; win_lat[k] = win_lat[k+1];
                        win_lon[k] = win_lon[k+1];   win_alt[k] = win_alt[k+1];
                    end
                    win_time[3] = r.stime; win_lat[3] = r.lat;
                    win_lon[3] = r.lon;    win_alt[3] = r.alt;
                    f.accepted = 1'b1;
                end
            end
            tsi_pkg::OP_QUERY: begin
                spline_at(r.stime, la, lo, al);
                f.lat = 24'(clamp(la, -tsi_pkg::LAT_MAX, tsi_pkg::LAT_MAX));
                f.lon = 25'(clamp(lo, -tsi_pkg::LON_MAX, tsi_pkg::LON_MAX));
                f.alt = 16'(clamp(al, tsi_pkg::ALT_MIN, tsi_pkg::ALT_MAX));
            end
            tsi_pkg::OP_CLEAR: begin
                for (int k = 0; k < 4; k++) begin
                    win_time[k] = '0; win_lat[k] = '0;
                    win_lon[k] = '0;  win_alt[k] = '0;
                end
                win_fill = 0;
            end
            default: ;
        endcase
        f.need_more = (win_fill < 4) ||
                      (longint'(win_time[2]) <=
                       longint'(r.stime) + longint'(tsi_pkg::NEED_MARGIN));
        f.tmin = win_time[0];
        f.tmax = win_time[0];
        for (int k = 1; k < 4; k++)
            if (win_time[k] > f.tmax) f.tmax = win_time[k];
        return f;
    endfunction

    // driver: offers queued requests, gaps at random, and a random receiver ready
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && !in_taken) begin
                // hold the offered request
            end else if (pending_reqs.size() > 0 &&
                         $urandom_range(99) >= send_idle_pct) begin
                t_request r;
                r = pending_reqs.pop_front();
                s_axis_tdata  <= {4'd0, r.alt, r.lon, r.lat, r.stime, r.op};
                s_axis_tvalid <= 1'b1;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
            m_axis_tready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // monitor: predicts on accepted requests, checks accepted results
    always @(posedge i_clk) begin
        in_taken <= i_rst_n && s_axis_tvalid && s_axis_tready;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                t_request r;
                r = {s_axis_tdata[1:0], s_axis_tdata[26:2], s_axis_tdata[50:27],
                     s_axis_tdata[75:51], s_axis_tdata[91:76]};
                expected_fixes.push_back(predict_fix(r));
                n_sent++;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                t_fix got, want;
                got = {m_axis_tdata[23:0], m_axis_tdata[48:24], m_axis_tdata[64:49],
                       m_axis_tdata[65], m_axis_tdata[66], m_axis_tdata[91:67],
                       m_axis_tdata[116:92]};
                n_checked++;
                if (expected_fixes.size() == 0) begin
                    $error("result with no request pending");
                    errors++;
                end else begin
                    want = expected_fixes.pop_front();
                    if (got.lat !== want.lat) begin
                        $error("lat_out exp %0d got %0d", want.lat, got.lat); errors++;
                    end
                    if (got.lon !== want.lon) begin
                        $error("lon_out exp %0d got %0d", want.lon, got.lon); errors++;
                    end
                    if (got.alt !== want.alt) begin
                        $error("alt_out exp %0d got %0d", want.alt, got.alt); errors++;
                    end
                    if (got.accepted !== want.accepted) begin
                        $error("point_accepted exp %0d got %0d", want.accepted,
                               got.accepted); errors++;
                    end
                    if (got.need_more !== want.need_more) begin
                        $error("need_more exp %0d got %0d", want.need_more,
                               got.need_more); errors++;
                    end
                    if (got.tmin !== want.tmin) begin
                        $error("window_min_time exp %0d got %0d", want.tmin,
                               got.tmin); errors++;
                    end
                    if (got.tmax !== want.tmax) begin
                        $error("window_max_time exp %0d got %0d", want.tmax,
                               got.tmax); errors++;
                    end
                end
            end
        end
    end

    // watchdog: cycles with no handshake on either side and no APB select
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
            timed_out = 1'b1;
            $display("watchdog expired, %0d results outstanding", expected_fixes.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic write_tension(input logic [16:0] value);
        @(negedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= 2'd0; pwdata <= {15'd0, value};
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        mdl_tension = value;
    endtask

    // block idle: queue empty, nothing offered or predicted outstanding
    task automatic wait_idle();
        while (pending_reqs.size() > 0 || s_axis_tvalid || expected_fixes.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic t_request make_req(logic [1:0] op, logic [24:0] t,
                                          int la, int lo, int al);
        t_request r;
        r.op = op; r.stime = t; r.lat = 24'(la); r.lon = 25'(lo); r.alt = 16'(al);
        return r;
    endfunction

    function automatic t_request rand_point(logic [24:0] t);
        return make_req(tsi_pkg::OP_PUSH, t,
                        $urandom_range(10800000) - 5400000,
                        $urandom_range(21600000) - 10800000,
                        $urandom_range(21000) - 1000);
    endfunction

    // a track: mostly rising times, queries near the newest time, some noise
    task automatic queue_track(int n_items);
        logic [24:0] t;
        int          r, step;
        t = 25'($urandom_range(22000000));
        for (int i = 0; i < n_items; i++) begin
            r = $urandom_range(99);
            step = ($urandom_range(3) == 0) ? $urandom_range(2000) : $urandom_range(60);
            if (r < 35) begin
                t = (t + step > 22118399) ? 25'($urandom_range(1000)) : t + 25'(step);
                pending_reqs.push_back(rand_point(t));
            end else if (r < 85) begin
                // query near the newest times, sometimes past the edges
                pending_reqs.push_back(make_req(tsi_pkg::OP_QUERY,
                    (t > 25'd3000) ? t - 25'($urandom_range(3000)) : t, 0, 0, 0));
            end else if (r < 90) begin
                pending_reqs.push_back(rand_point(25'($urandom_range(22118399))));
            end else if (r < 93) begin
                pending_reqs.push_back(make_req(tsi_pkg::OP_CLEAR, t, 0, 0, 0));
            end else if (r < 95) begin
                pending_reqs.push_back(make_req(tsi_pkg::OP_SPARE, t, 0, 0, 0));
            end else begin
                // raw noise over every input bit
                pending_reqs.push_back(t_request'(92'({$urandom, $urandom, $urandom})));
            end
        end
    endtask

    initial begin
        mdl_tension = tsi_pkg::TENSION_RESET;
        win_fill = 0;
        for (int k = 0; k < 4; k++) begin
            win_time[k] = '0; win_lat[k] = '0; win_lon[k] = '0; win_alt[k] = '0;
        end
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty window, partial fill, extremes, refill, equal times
        send_idle_pct = 12; recv_idle_pct = 57;
        pending_reqs.push_back(make_req(tsi_pkg::OP_QUERY, 25'd0, 0, 0, 0));
        pending_reqs.push_back(make_req(tsi_pkg::OP_PUSH, 25'd100, 5400000, 10800000, 20000));
        pending_reqs.push_back(make_req(tsi_pkg::OP_QUERY, 25'd100, 0, 0, 0));
        pending_reqs.push_back(make_req(tsi_pkg::OP_PUSH, 25'd200, -5400000, -10800000, -1000));
        pending_reqs.push_back(make_req(tsi_pkg::OP_PUSH, 25'd200, 5400000, 10800000, 20000));
        pending_reqs.push_back(make_req(tsi_pkg::OP_PUSH, 25'd400, -5400000, -10800000, -1000));
        pending_reqs.push_back(make_req(tsi_pkg::OP_QUERY, 25'd200, 0, 0, 0));
        pending_reqs.push_back(make_req(tsi_pkg::OP_PUSH, 25'd500, 5400000, 10800000, 20000));
        pending_reqs.push_back(make_req(tsi_pkg::OP_QUERY, 25'd150, 0, 0, 0));
        pending_reqs.push_back(make_req(tsi_pkg::OP_QUERY, 25'd300, 0, 0, 0));
        pending_reqs.push_back(make_req(tsi_pkg::OP_QUERY, 25'd374, 0, 0, 0));
        pending_reqs.push_back(make_req(tsi_pkg::OP_QUERY, 25'd450, 0, 0, 0));
        pending_reqs.push_back(make_req(tsi_pkg::OP_PUSH, 25'd50, 1, -1, 7));
        pending_reqs.push_back(make_req(tsi_pkg::OP_QUERY, 25'd50, 0, 0, 0));
        pending_reqs.push_back(make_req(tsi_pkg::OP_SPARE, 25'd22118399, 0, 0, 0));
        pending_reqs.push_back(make_req(tsi_pkg::OP_CLEAR, 25'd22118399, 0, 0, 0));
        pending_reqs.push_back(make_req(tsi_pkg::OP_PUSH, 25'd22118000, 0, 0, 0));
        pending_reqs.push_back(make_req(tsi_pkg::OP_PUSH, 25'd22118100, 100, 200, 30));
        pending_reqs.push_back(make_req(tsi_pkg::OP_PUSH, 25'd22118300, 300, 100, 10));
        pending_reqs.push_back(make_req(tsi_pkg::OP_PUSH, 25'd22118399, -200, 900, 5));
        pending_reqs.push_back(make_req(tsi_pkg::OP_QUERY, 25'd22118200, 0, 0, 0));
        wait_idle();

        // random phases across tension settings
        write_tension(17'd0);
        queue_track(350);
        wait_idle();
        write_tension(17'd65536);
        send_idle_pct = 57; recv_idle_pct = 12;
        queue_track(350);
        wait_idle();
        write_tension(17'h1FFFF);
        send_idle_pct = 0; recv_idle_pct = 0;
        queue_track(350);
        // long receiver hold-off while the sender keeps offering
        recv_hold = 1'b1;
        repeat (400) @(posedge i_clk);
        recv_hold = 1'b0;
        wait_idle();
        write_tension(17'($urandom_range(65536)));
        queue_track(380);
        wait_idle();

        $display("%0d requests, %0d results checked, %0d interpolated queries",
                 n_sent, n_checked, n_interp);
        $display("tension covered at 0, 1.0, maximum and random, with idling both sides");
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire

>>> sim.f
sv/tsi_pkg.sv
sv/tsi_datapath.sv
sv/tsi_ctrl.sv
sv/track_spline_interpolator.sv
bench/track_spline_interpolator_tb.sv
